/* design/bdq_pkg.sv */
// Shared types and constants for the bounded double-ended queue.
package bdq_pkg;

  // Default number of entries in the circular store.
  localparam int DEPTH_DEF = 32;

  // Request codes carried in req_type.
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_LIST       = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // One request beat.
  typedef struct packed {
    logic        [2:0]  req_type;
    logic signed [31:0] push_value;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic signed [31:0] out_value;
    logic        [1:0]  status;
    logic               last_of_run;
  } rsp_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_POP_DATA,
    S_LIST_DATA
  } state_t;

  // Commands from the controller to the datapath.
  typedef enum logic [2:0] {
    DP_NONE,
    DP_LATCH,
    DP_SHORT_RESULT,
    DP_POP_START,
    DP_POP_RESULT,
    DP_LIST_START,
    DP_LIST_RESULT
  } dp_op_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] req_type;
    logic       empty;
    logic       full;
    logic       out_free;
    logic       list_last;
  } dp_stat_t;

endpackage

/* design/bdq_ctrl.sv */
// Controller state machine that sequences requests through the deque datapath.
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_next = state;
    op         = DP_NONE;
    req_stall  = 1'b1;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          op         = DP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.req_type inside {REQ_PUSH_FRONT, REQ_PUSH_BACK}) begin
          // A push finishes in one step once the result register is free.
          if (stat.out_free) begin
            op         = DP_SHORT_RESULT;
            state_next = S_IDLE;
          end
        end else if (stat.req_type inside {REQ_POP_FRONT, REQ_POP_BACK}) begin
          if (stat.empty) begin
            if (stat.out_free) begin
              op         = DP_SHORT_RESULT;
              state_next = S_IDLE;
            end
          end else begin
            op         = DP_POP_START;
            state_next = S_POP_DATA;
          end
        end else if (stat.req_type == REQ_LIST) begin
          if (stat.empty) begin
            if (stat.out_free) begin
              op         = DP_SHORT_RESULT;
              state_next = S_IDLE;
            end
          end else begin
            op         = DP_LIST_START;
            state_next = S_LIST_DATA;
          end
        end else begin
          // Unknown codes produce nothing.
          state_next = S_IDLE;
        end
      end
      S_POP_DATA: begin
        if (stat.out_free) begin
          op         = DP_POP_RESULT;
          state_next = S_IDLE;
        end
      end
      S_LIST_DATA: begin
        if (stat.out_free) begin
          op = DP_LIST_RESULT;
          if (stat.list_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/bdq_dp.sv */
// Datapath of the deque: entry memory, pointers, request and result registers.
module bdq_dp
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  dp_op_t   op,
  output dp_stat_t stat,
  input  req_t     req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output rsp_t     rsp
);

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam logic [SLOT_W:0]  DEPTH_S  = (SLOT_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

  // Add two slot numbers below DEPTH and wrap once.
  function automatic logic [SLOT_W-1:0] wrap_add(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
    logic [SLOT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[SLOT_W-1:0];
  endfunction

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;
  logic               rd_en;
  logic [SLOT_W-1:0]  rd_addr;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;

  req_t              cur;
  logic [SLOT_W-1:0] front;
  logic [SLOT_W-1:0] front_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] idx_next;

  logic              empty;
  logic              full;
  logic              out_free;
  logic              list_last;
  logic              is_push;
  logic [SLOT_W-1:0] front_dec;
  logic [SLOT_W-1:0] front_inc;
  logic [SLOT_W-1:0] back_slot;
  logic [SLOT_W-1:0] tail_slot;
  logic              out_load;
  rsp_t              out_new;

  // Status toward the controller.
  assign empty     = (count == '0);
  assign full      = (count == DEPTH_C);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign list_last = ({1'b0, idx} + 1'b1) == (SLOT_W + 1)'(count);
  assign is_push   = (cur.req_type == REQ_PUSH_FRONT) || (cur.req_type == REQ_PUSH_BACK);

  always_comb begin
    stat.req_type  = cur.req_type;
    stat.empty     = empty;
    stat.full      = full;
    stat.out_free  = out_free;
    stat.list_last = list_last;
  end

  // Slot arithmetic around the circular store.
  assign front_dec = (front == '0) ? LAST_SLOT : front - 1'b1;
  assign front_inc = wrap_add(front, SLOT_W'(1));
  assign back_slot = wrap_add(front, SLOT_W'(count - 1'b1));
  assign tail_slot = wrap_add(front, SLOT_W'(count));

  // Command decode: pointer updates, memory access and result formation.
  always_comb begin
    front_next = front;
    count_next = count;
    idx_next   = idx;
    wr_en      = 1'b0;
    wr_addr    = tail_slot;
    rd_en      = 1'b0;
    rd_addr    = front;
    out_load   = 1'b0;
    out_new    = '0;
    case (op)
      DP_SHORT_RESULT: begin
        out_load            = 1'b1;
        out_new.last_of_run = 1'b1;
        if (is_push) begin
          if (full) begin
            out_new.status = ST_FULL;
          end else begin
            out_new.status = ST_OK;
            wr_en          = 1'b1;
            count_next     = count + 1'b1;
            if (cur.req_type == REQ_PUSH_FRONT) begin
              wr_addr    = front_dec;
              front_next = front_dec;
            end
          end
        end else begin
          out_new.status = ST_EMPTY;
        end
      end
      DP_POP_START: begin
        rd_en      = 1'b1;
        count_next = count - 1'b1;
        if (cur.req_type == REQ_POP_FRONT) begin
          rd_addr    = front;
          front_next = front_inc;
        end else begin
          rd_addr = back_slot;
        end
      end
      DP_POP_RESULT: begin
        out_load            = 1'b1;
        out_new.out_value   = rd_data;
        out_new.status      = ST_OK;
        out_new.last_of_run = 1'b1;
      end
      DP_LIST_START: begin
        rd_en    = 1'b1;
        rd_addr  = front;
        idx_next = '0;
      end
      DP_LIST_RESULT: begin
        out_load            = 1'b1;
        out_new.out_value   = rd_data;
        out_new.status      = ST_OK;
        out_new.last_of_run = list_last;
        if (!list_last) begin
          idx_next = idx + 1'b1;
          rd_en    = 1'b1;
          rd_addr  = wrap_add(front, idx + 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cur.push_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Request register, loaded when a beat is accepted.
  always_ff @(posedge clk) begin
    if (op == DP_LATCH) begin
      cur <= req;
    end
    idx <= idx_next;
  end

  // Pointer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else begin
      front <= front_next;
      count <= count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp <= out_new;
    end
  end

  // The fill count never passes the store size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("entry count above depth");

  // The front slot always names a real entry.
  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, front} < DEPTH_S)
    else $error("front slot out of range");

  // An accepted push into a deque with room grows it by one.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (op == DP_SHORT_RESULT && is_push && !full) |=> (count == $past(count) + 1'b1))
    else $error("push did not grow the deque");

  // Error results carry a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_OK) |-> (rsp.out_value == 0))
    else $error("error result with nonzero value");

endmodule

/* design/bounded_deque.sv */
// Top level of the bounded double-ended queue.
// A request beat is taken only when the block is idle; the controller then
// walks it through the datapath's entry memory, which has separate read and
// write ports and registered read data. A push, or any request that ends in
// an error status, goes from the request register through the decode state
// into the result register; the block is idle again in the same cycle that
// the result appears. A pop adds a memory read state. A listing of N entries
// reads one entry per cycle while the result side does not stall and gives N
// results. An unknown code gives no result and frees the block. A stall on
// the result side holds the result register and delays the next step; a new
// request can still be taken while a finished result waits.
module bounded_deque
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  dp_op_t   op;
  dp_stat_t stat;

  // Sequencer.
  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .op        (op)
  );

  // Storage and result path.
  bdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .stat      (stat),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
